>>> sv/nibble_map_heap_manager_defines.svh
// assertion helpers for the nibble map heap manager
`ifndef NIBBLE_MAP_HEAP_MANAGER_DEFINES_SVH
`define NIBBLE_MAP_HEAP_MANAGER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define NMHM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define NMHM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nmhm_pkg.sv
package nmhm_pkg;

    localparam int USE_BYTES = 1024;
    localparam int IDX_W     = $clog2(USE_BYTES);
    localparam int CNT_W     = $clog2(USE_BYTES + 1);
    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 11;
    localparam int PID_W     = 4;
    localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic [LEN_W-1:0] LEN_MAX    = '1;
    localparam logic [PID_W-1:0] ENTRY_FREE = 4'd0;
    localparam logic [PID_W-1:0] ENTRY_CONT = 4'd15;

    typedef logic [PID_W-1:0] t_entry;

    typedef enum logic [2:0] {
        REQ_WRITE      = 3'd0,
        REQ_READ       = 3'd1,
        REQ_FREE       = 3'd2,
        REQ_FREE_OWNER = 3'd3,
        REQ_SIZE       = 3'd4,
        REQ_FREE_PROC  = 3'd5,
        REQ_RESIZE     = 3'd6
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_ADDR    = 3'd1,
        ST_NOT_ALLOC   = 3'd2,
        ST_NOT_OWNER   = 3'd3,
        ST_NO_ROOM     = 3'd4
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic [ADDR_W-1:0]  address;
        t_entry             process_id;
        t_entry             current_process;
        logic [LEN_W-1:0]   new_size;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  chunk_addr;
        logic [LEN_W-1:0]   chunk_length;
        t_entry             entry_value;
    } t_res;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        t_entry             wdata;
        logic [IDX_W-1:0]   raddr;
    } t_ram_ctl;

    // saturate a chunk length to the result field
    function automatic logic [LEN_W-1:0] clip_len(input logic [CNT_W-1:0] n);
        logic [CMP_W-1:0] t;
        t = CMP_W'(n);
        if (t > CMP_W'(LEN_MAX)) begin
            return LEN_MAX;
        end
        return t[LEN_W-1:0];
    endfunction

endpackage

>>> sv/nmhm_ram.sv
module nmhm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/nmhm_ctrl.sv
module nmhm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [nmhm_pkg::ADDR_W-1:0] i_use_start,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  nmhm_pkg::t_req              i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output nmhm_pkg::t_res              o_res,
    output nmhm_pkg::t_ram_ctl          o_ram,
    input  nmhm_pkg::t_entry            i_rdata
);

    import nmhm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_READ_OUT, S_BACK, S_FWD, S_FILL, S_SWEEP, S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    t_res               r_res, n_res;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [IDX_W-1:0]   r_start, n_start;
    logic [CNT_W-1:0]   r_end, n_end;
    logic               r_grow, n_grow;
    logic               r_clr_all, n_clr_all;
    logic               r_freeing, n_freeing;

    logic [ADDR_W:0]    diff;
    logic               addr_ok;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   ptr_lo;
    logic [CNT_W-1:0]   cnt;
    logic               in_area;
    logic [ADDR_W-1:0]  start_addr;
    t_entry             want;
    logic               sweep_free;
    t_res               res_zero;

    always_comb begin
        diff       = {1'b0, r_req.address} - {1'b0, i_use_start};
        addr_ok    = diff < (ADDR_W + 1)'(USE_BYTES);
        idx        = diff[IDX_W-1:0];
        ptr_lo     = r_ptr[IDX_W-1:0];
        cnt        = r_ptr - CNT_W'(r_start);
        in_area    = r_ptr < CNT_W'(USE_BYTES);
        start_addr = ADDR_W'(r_start) + i_use_start;
        want       = (r_req.req_type == REQ_FREE) ? r_req.current_process
                                                  : r_req.process_id;
        res_zero   = '{status: ST_OK, chunk_addr: '0, chunk_length: '0, entry_value: '0};
        if (i_rdata == ENTRY_FREE) begin
            sweep_free = 1'b0;
        end else if (i_rdata != ENTRY_CONT) begin
            sweep_free = (i_rdata == r_req.process_id);
        end else begin
            sweep_free = r_freeing;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_ptr     = r_ptr;
        n_start   = r_start;
        n_end     = r_end;
        n_grow    = r_grow;
        n_clr_all = r_clr_all;
        n_freeing = r_freeing;
        o_ram     = '{we: 1'b0, waddr: ptr_lo, wdata: ENTRY_FREE, raddr: ptr_lo};

        unique case (r_state)
            S_CLEAR: begin
                o_ram.we = 1'b1;
                n_ptr    = r_ptr + 1'b1;
                if (ptr_lo == IDX_W'(USE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res     = res_zero;
                n_grow    = 1'b0;
                n_clr_all = (r_req.req_type == REQ_FREE) ||
                            (r_req.req_type == REQ_FREE_OWNER);
                if (r_req.req_type == REQ_FREE_PROC) begin
                    o_ram.raddr = '0;
                    n_ptr       = '0;
                    n_freeing   = 1'b0;
                    n_state     = S_SWEEP;
                end else if (r_req.req_type != REQ_WRITE && r_req.req_type != REQ_READ &&
                             r_req.req_type != REQ_FREE && r_req.req_type != REQ_FREE_OWNER &&
                             r_req.req_type != REQ_SIZE && r_req.req_type != REQ_RESIZE) begin
                    // unused request code, answered with an all-zero word
                    n_state = S_DONE;
                end else if (!addr_ok) begin
                    n_res.status = ST_BAD_ADDR;
                    n_state      = S_DONE;
                end else if (r_req.req_type == REQ_WRITE) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = idx;
                    o_ram.wdata = r_req.process_id;
                    n_state     = S_DONE;
                end else if (r_req.req_type == REQ_READ) begin
                    o_ram.raddr = idx;
                    n_state     = S_READ_OUT;
                end else begin
                    o_ram.raddr = idx;
                    n_ptr       = CNT_W'(idx);
                    n_state     = S_BACK;
                end
            end
            S_READ_OUT: begin
                n_res.entry_value = i_rdata;
                n_state           = S_DONE;
            end
            S_BACK: begin
                if (i_rdata == ENTRY_CONT && ptr_lo != '0) begin
                    o_ram.raddr = ptr_lo - 1'b1;
                    n_ptr       = r_ptr - 1'b1;
                end else begin
                    o_ram.raddr = ptr_lo + 1'b1;
                    if (i_rdata == ENTRY_FREE || i_rdata == ENTRY_CONT) begin
                        n_res.status = ST_NOT_ALLOC;
                        n_state      = S_DONE;
                    end else if (r_clr_all && i_rdata != want) begin
                        n_res.status = ST_NOT_OWNER;
                        n_state      = S_DONE;
                    end else begin
                        n_start = ptr_lo;
                        n_ptr   = r_ptr + 1'b1;
                        if (r_clr_all || (r_req.req_type == REQ_RESIZE &&
                                          r_req.new_size == '0)) begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = ptr_lo;
                        end
                        n_state = S_FWD;
                    end
                end
            end
            S_FWD: begin
                o_ram.raddr = ptr_lo + 1'b1;
                if (!r_grow) begin
                    if (in_area && i_rdata == ENTRY_CONT) begin
                        // offsets at or past the new size fall away on a shrink
                        if (r_clr_all || (r_req.req_type == REQ_RESIZE &&
                                          CMP_W'(cnt) >= CMP_W'(r_req.new_size))) begin
                            o_ram.we = 1'b1;
                        end
                        n_ptr = r_ptr + 1'b1;
                    end else if (r_req.req_type == REQ_RESIZE &&
                                 CMP_W'(r_req.new_size) > CMP_W'(cnt)) begin
                        n_end = cnt;
                        if (in_area && i_rdata == ENTRY_FREE) begin
                            n_grow = 1'b1;
                            n_ptr  = r_ptr + 1'b1;
                        end else begin
                            n_res.status = ST_NO_ROOM;
                            n_state      = S_DONE;
                        end
                    end else begin
                        n_res.chunk_addr = start_addr;
                        if (r_req.req_type == REQ_RESIZE &&
                            CMP_W'(r_req.new_size) != CMP_W'(cnt)) begin
                            n_res.chunk_length = r_req.new_size;
                        end else begin
                            n_res.chunk_length = clip_len(cnt);
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    if (CMP_W'(cnt) == CMP_W'(r_req.new_size)) begin
                        // room found: mark from the old end up to here
                        n_ptr   = CNT_W'(r_start) + r_end;
                        n_end   = r_ptr;
                        n_state = S_FILL;
                    end else if (in_area && i_rdata == ENTRY_FREE) begin
                        n_ptr = r_ptr + 1'b1;
                    end else begin
                        n_res.status = ST_NO_ROOM;
                        n_state      = S_DONE;
                    end
                end
            end
            S_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = ENTRY_CONT;
                n_ptr       = r_ptr + 1'b1;
                if (r_ptr + 1'b1 == r_end) begin
                    n_res.chunk_addr   = start_addr;
                    n_res.chunk_length = r_req.new_size;
                    n_state            = S_DONE;
                end
            end
            S_SWEEP: begin
                o_ram.raddr = ptr_lo + 1'b1;
                o_ram.we    = sweep_free;
                n_freeing   = sweep_free;
                n_ptr       = r_ptr + 1'b1;
                if (ptr_lo == IDX_W'(USE_BYTES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ptr     <= '0;
            r_grow    <= 1'b0;
            r_clr_all <= 1'b0;
            r_freeing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_grow    <= n_grow;
            r_clr_all <= n_clr_all;
            r_freeing <= n_freeing;
        end
        r_req   <= n_req;
        r_res   <= n_res;
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

>>> sv/nibble_map_heap_manager.sv
// channel | dir | handshake             | payload
// s       | in  | i_s_tvalid/o_s_tready | i_s_tdata 40b, i_s_tuser 3b (request code)
// m       | out | o_m_tvalid/i_m_tready | o_m_tdata 32b, o_m_tuser 3b (status)
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_data 16b (use_start)
//
// one request at a time; the sequencer walks the map one map entry per cycle:
//   write entry, read entry and bad address need no walk; a sweep of a process visits every entry
//   free, size, resize: steps back to the chunk start, then forward over the chunk
//   (plus the free bytes probed and filled when growing)
// after reset a clearing pass writes every map entry, no request taken
// the result sits in an output register so a stalled m side holds only one word
`include "nibble_map_heap_manager_defines.svh"

module nibble_map_heap_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // address[15:0], process_id[19:16],
                                     // current_process[23:20], new_size[34:24], zero fill
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // master result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // chunk_addr[15:0], chunk_length[26:16],
                                     // entry_value[30:27], zero fill
    output logic [2:0]  o_m_tuser,   // status[2:0]
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    import nmhm_pkg::*;

    logic [ADDR_W-1:0] r_use_start;
    logic              r_out_valid;
    t_res              r_out;

    t_req              req;
    t_res              res;
    logic              res_valid;
    logic              res_ready;
    t_ram_ctl          ram_ctl;
    t_entry            rdata;

    // unpack the request word
    assign req = '{req_type:        t_req_type'(i_s_tuser),
                   address:         i_s_tdata[15:0],
                   process_id:      i_s_tdata[19:16],
                   current_process: i_s_tdata[23:20],
                   new_size:        i_s_tdata[34:24]};

    // config is always taken; the sequencer only reads it while busy
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_start <= '0;
        end else if (i_cfg_valid) begin
            r_use_start <= i_cfg_data;
        end
    end

    nmhm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_use_start (r_use_start),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram_ctl),
        .i_rdata     (rdata)
    );

    // allocation map, one nibble per use-area byte
    nmhm_ram #(
        .WIDTH (PID_W),
        .DEPTH (USE_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (ram_ctl.waddr),
        .i_wdata (ram_ctl.wdata),
        .i_raddr (ram_ctl.raddr),
        .o_rdata (rdata)
    );

    // output register: refilled as soon as the held word leaves
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.entry_value, r_out.chunk_length, r_out.chunk_addr};
    assign o_m_tuser  = r_out.status;

    // an idle sequencer never writes the map
    `NMHM_ASSERT_IMP(a_idle_no_write, o_s_tready, !ram_ctl.we, "map written while idle")
    // a taken request keeps the slave side closed in the next cycle
    `NMHM_ASSERT_NXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready,
        "ready after accept")
    // a new result only appears out of a busy sequencer
    `NMHM_ASSERT_IMP(a_result_from_busy, $rose(o_m_tvalid), !$past(o_s_tready),
        "result without request")
    // failures carry no chunk information
    `NMHM_ASSERT_IMP(a_fail_zero, o_m_tvalid && (o_m_tuser != ST_OK),
        (o_m_tdata[15:0] == '0) && (o_m_tdata[26:16] == '0), "failure with chunk data")

endmodule
